FILE: rtl/ale_pkg.sv
`default_nettype none

package ale_pkg;

   // operation codes carried on the request channel
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOCATE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // status codes carried on the response channel
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // what the data read from the store is used for in the cycle after the read
   typedef enum logic [1:0] {
      TAG_NONE,
      TAG_MOVE,
      TAG_REMOVED,
      TAG_COMPARE
   } tag_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_READ,
      S_DEL_SHIFT,
      S_LOC_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic    accept;
      tag_type rd_tag;
      logic    k_inc;
      logic    k_dec;
      logic    put;
      logic    finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   err_ok;
      logic   ins_more;
      logic   del_more;
      logic   loc_more;
      logic   rd_busy;
      logic   rsp_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/ale_ctrl.sv
`default_nettype none

module ale_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ale_pkg::stat_type stat,
   output ale_pkg::cmd_type       cmd
);

   ale_pkg::state_type state_ff;
   ale_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ale_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ale_pkg::S_IDLE: begin
            if (req_valid) state_in = ale_pkg::S_DECODE;
         end
         ale_pkg::S_DECODE: begin
            if (!stat.err_ok) begin
               state_in = ale_pkg::S_DONE;
            end else begin
               case (stat.op)
                  ale_pkg::OP_INSERT: state_in = ale_pkg::S_INS_SHIFT;
                  ale_pkg::OP_DELETE: state_in = ale_pkg::S_DEL_READ;
                  ale_pkg::OP_LOCATE: state_in = ale_pkg::S_LOC_SCAN;
                  default:            state_in = ale_pkg::S_DONE;
               endcase
            end
         end
         ale_pkg::S_INS_SHIFT: begin
            if (!stat.ins_more) state_in = ale_pkg::S_INS_PUT;
         end
         ale_pkg::S_INS_PUT: begin
            if (!stat.rd_busy) state_in = ale_pkg::S_DONE;
         end
         ale_pkg::S_DEL_READ: begin
            state_in = ale_pkg::S_DEL_SHIFT;
         end
         ale_pkg::S_DEL_SHIFT: begin
            if (!stat.del_more) state_in = ale_pkg::S_DRAIN;
         end
         ale_pkg::S_LOC_SCAN: begin
            if (!stat.loc_more) state_in = ale_pkg::S_DRAIN;
         end
         ale_pkg::S_DRAIN: begin
            if (!stat.rd_busy) state_in = ale_pkg::S_DONE;
         end
         ale_pkg::S_DONE: begin
            if (stat.rsp_free) state_in = ale_pkg::S_IDLE;
         end
         default: begin
            state_in = ale_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_tag = ale_pkg::TAG_NONE;
      req_stall  = (state_ff != ale_pkg::S_IDLE);
      case (state_ff)
         ale_pkg::S_IDLE: begin
            cmd.accept = req_valid;
         end
         ale_pkg::S_INS_SHIFT: begin
            if (stat.ins_more) begin
               cmd.rd_tag = ale_pkg::TAG_MOVE;
               cmd.k_dec  = 1'b1;
            end
         end
         ale_pkg::S_INS_PUT: begin
            cmd.put = !stat.rd_busy;
         end
         ale_pkg::S_DEL_READ: begin
            cmd.rd_tag = ale_pkg::TAG_REMOVED;
            cmd.k_inc  = 1'b1;
         end
         ale_pkg::S_DEL_SHIFT: begin
            if (stat.del_more) begin
               cmd.rd_tag = ale_pkg::TAG_MOVE;
               cmd.k_inc  = 1'b1;
            end
         end
         ale_pkg::S_LOC_SCAN: begin
            if (stat.loc_more) begin
               cmd.rd_tag = ale_pkg::TAG_COMPARE;
               cmd.k_inc  = 1'b1;
            end
         end
         ale_pkg::S_DONE: begin
            cmd.finish = stat.rsp_free;
         end
         default: begin
            cmd.accept = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/ale_dp.sv
`default_nettype none

module ale_dp #(
   parameter int CAPACITY = 128
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          req_operation,
   input  wire logic [7:0]          req_position,
   input  wire logic signed [31:0]  req_value,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_removed_value,
   output logic [7:0]               rsp_found_position,
   output logic [7:0]               rsp_list_length,
   input  wire ale_pkg::cmd_type    cmd,
   output ale_pkg::stat_type        stat
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

   logic signed [31:0] entry_store_ff [CAPACITY];

   ale_pkg::op_type     op_ff;
   logic [7:0]          pos_ff;
   logic signed [31:0]  value_ff;
   ale_pkg::status_type err_ff;
   ale_pkg::status_type err_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       k_ff;
   logic [CW-1:0]       k_in;
   ale_pkg::tag_type    tag_ff;
   logic [AW-1:0]       dest_ff;
   logic [CW-1:0]       slot_ff;
   logic signed [31:0]  rdata_ff;
   logic signed [31:0]  removed_ff;
   logic                hit_ff;
   logic [CW-1:0]       found_ff;

   logic                rsp_valid_ff;
   ale_pkg::status_type rsp_status_ff;
   logic signed [31:0]  rsp_removed_ff;
   logic [7:0]          rsp_found_ff;
   logic [7:0]          rsp_length_ff;

   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       mv_dest;
   logic [AW-1:0]       put_addr;
   ale_pkg::op_type     req_op;
   logic [CMPW-1:0]     req_pos_x;
   logic [CMPW-1:0]     cnt_x;

   assign req_op    = ale_pkg::op_type'(req_operation);
   assign req_pos_x = CMPW'(req_position);
   assign cnt_x     = CMPW'(count_ff);

   // position checks against the current length
   always_comb begin
      err_in = ale_pkg::ST_OK;
      k_in   = '0;
      case (req_op)
         ale_pkg::OP_INSERT: begin
            k_in = count_ff;
            if (req_position == 8'd0 || req_pos_x > cnt_x + CMPW'(1)) begin
               err_in = ale_pkg::ST_BAD_POS;
            end else if (count_ff == CW'(CAPACITY)) begin
               err_in = ale_pkg::ST_FULL;
            end
         end
         ale_pkg::OP_DELETE: begin
            k_in = CW'(req_pos_x - CMPW'(1));
            if (req_position == 8'd0 || req_pos_x > cnt_x) begin
               err_in = ale_pkg::ST_BAD_POS;
            end
         end
         default: begin
            err_in = ale_pkg::ST_OK;
         end
      endcase
   end

   // insert walks down from the tail, delete and locate walk up
   always_comb begin
      if (op_ff == ale_pkg::OP_INSERT) begin
         rd_addr = AW'(k_ff - CW'(1));
         mv_dest = AW'(k_ff);
      end else begin
         rd_addr = AW'(k_ff);
         mv_dest = AW'(k_ff - CW'(1));
      end
      put_addr = AW'(CMPW'(pos_ff) - CMPW'(1));
   end

   always_comb begin
      count_in = count_ff;
      if (err_ff == ale_pkg::ST_OK) begin
         case (op_ff)
            ale_pkg::OP_INSERT: count_in = count_ff + CW'(1);
            ale_pkg::OP_DELETE: count_in = count_ff - CW'(1);
            ale_pkg::OP_CLEAR:  count_in = '0;
            default:            count_in = count_ff;
         endcase
      end
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (tag_ff == ale_pkg::TAG_MOVE) begin
         entry_store_ff[dest_ff] <= rdata_ff;
      end else if (cmd.put) begin
         entry_store_ff[put_addr] <= value_ff;
      end
      if (cmd.rd_tag != ale_pkg::TAG_NONE) begin
         rdata_ff <= entry_store_ff[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         pos_ff   <= req_position;
         value_ff <= req_value;
         err_ff   <= err_in;
         k_ff     <= k_in;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + CW'(1);
      end else if (cmd.k_dec) begin
         k_ff <= k_ff - CW'(1);
      end
      dest_ff <= mv_dest;
      slot_ff <= k_ff + CW'(1);
      if (tag_ff == ale_pkg::TAG_REMOVED) begin
         removed_ff <= rdata_ff;
      end
      if (tag_ff == ale_pkg::TAG_COMPARE && !hit_ff && rdata_ff == value_ff) begin
         found_ff <= slot_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff  <= err_ff;
         rsp_removed_ff <= '0;
         rsp_found_ff   <= '0;
         rsp_length_ff  <= 8'(count_in);
         if (op_ff == ale_pkg::OP_LOCATE) begin
            rsp_status_ff <= hit_ff ? ale_pkg::ST_OK : ale_pkg::ST_NOT_FOUND;
            if (hit_ff) rsp_found_ff <= 8'(found_ff);
         end
         if (op_ff == ale_pkg::OP_DELETE && err_ff == ale_pkg::ST_OK) begin
            rsp_removed_ff <= removed_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tag_ff       <= ale_pkg::TAG_NONE;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_ff <= cmd.rd_tag;
         if (cmd.accept) begin
            hit_ff <= 1'b0;
         end else if (tag_ff == ale_pkg::TAG_COMPARE && rdata_ff == value_ff) begin
            hit_ff <= 1'b1;
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.op       = op_ff;
      stat.err_ok   = (err_ff == ale_pkg::ST_OK);
      stat.ins_more = (CMPW'(k_ff) >= CMPW'(pos_ff));
      stat.del_more = (k_ff < count_ff);
      stat.loc_more = (k_ff < count_ff) && !hit_ff;
      stat.rd_busy  = (tag_ff != ale_pkg::TAG_NONE);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_put_no_move: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> tag_ff != ale_pkg::TAG_MOVE)
      else $error("value write collides with a shift write");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> tag_ff == ale_pkg::TAG_NONE)
      else $error("result taken while a store read is in flight");

   a_full_only_full: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && err_ff == ale_pkg::ST_FULL |-> count_ff == CW'(CAPACITY))
      else $error("full status on a list with room");

   a_hit_locate: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> op_ff == ale_pkg::OP_LOCATE)
      else $error("match flag set outside locate");

endmodule

`default_nettype wire

FILE: rtl/array_list_engine.sv
// array_list_engine: ordered list of signed 32-bit values in a store of
// CAPACITY entries, one operation per request item and one response item
// per request.
// request channel (req_valid / req_stall): operation (insert, delete, locate,
// clear), 1-based position and value. response channel (rsp_valid /
// rsp_stall): status, removed value, found position and the new length.
// one request is worked on at a time; req_stall is low only while the
// block is idle. the store has one write and one registered read port, so
// shifting and scanning move one entry per cycle. insert shifts the entries
// from the position to the tail up by one, walking down from the tail, and
// then writes the value; delete reads the removed entry and shifts the later
// entries down; locate reads entries up to one entry past the first match;
// clear and any rejected position go straight to the response. the block
// returns to idle before it takes the next request. the response sits in an
// output register; a new request is taken while it waits, and the block
// holds the next result until the receiver drops rsp_stall.
// reset (synchronous, active high) empties the list and drops rsp_valid;
// the store itself is not cleared, since only held entries are ever read.
`default_nettype none

module array_list_engine #(
   parameter int CAPACITY = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [7:0]         req_position,
   input  wire logic signed [31:0] req_value,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_removed_value,
   output logic [7:0]              rsp_found_position,
   output logic [7:0]              rsp_list_length
);

   // command and status between sequencer and datapath
   ale_pkg::cmd_type  cmd;
   ale_pkg::stat_type stat;

   // sequencer: decode, shift / scan loops, response hand-off
   ale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: entry store, length, walk index, response register
   ale_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

`default_nettype wire

FILE: verif/array_list_engine_tb.sv
`timescale 1ns / 100ps

module array_list_engine_tb;

   localparam int LIST_CAPACITY = 128;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int POOL_SIZE     = 16;
   // long idle stretch on either side
   localparam int GAP_MAX       = 40;
   // receiver hold-off that lets the block back up into req_stall
   localparam int LONG_HOLD     = 500;
   localparam int HOLD_EVERY    = 700;
   // slowest legal run: every item shifts the whole store and waits out
   // the longest gap and stall, plus the hold-offs, then taken four times
   localparam int ITEM_BOUND    = 2000;
   localparam int CYCLE_LIMIT   =
      4 * (ITEM_BOUND * (LIST_CAPACITY + 5 + 2 * GAP_MAX) + 4 * LONG_HOLD);

   // one request item as the sender offers it
   typedef struct packed {
      ale_pkg::op_type     op;
      logic [7:0]          pos;
      logic signed [31:0]  val;
      logic                drain_first;   // hold back until all replies are in
   } list_cmd_type;

   // one response item as the block should return it
   typedef struct packed {
      ale_pkg::status_type status;
      logic signed [31:0]  removed;
      logic [7:0]          found;
      logic [7:0]          length;
   } list_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_operation = ale_pkg::OP_INSERT;
   logic [7:0]          req_position = '0;
   logic signed [31:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic signed [31:0]  rsp_removed_value;
   logic [7:0]          rsp_found_position;
   logic [7:0]          rsp_list_length;

   // items waiting to be offered, and replies the list should give back
   list_cmd_type        cmd_backlog[$];
   list_reply_type      expected_replies[$];
   list_cmd_type        in_flight;

   // the testbench's own picture of the list, advanced at each accepted item
   logic signed [31:0]  list_image[LIST_CAPACITY];
   int                  list_size = 0;

   // length the stimulus generator expects, used to aim positions
   int                  plan_len = 0;
   logic signed [31:0]  value_pool[POOL_SIZE];

   int                  mismatch_count = 0;
   int                  reply_index = 0;
   int                  reqs_taken = 0;
   int                  cycle_count = 0;
   int                  send_gap = 0;
   int                  send_calm = 0;
   int                  stall_left = 0;
   int                  recv_calm = 0;
   int                  hold_left = 0;
   int                  next_hold_at = 60;
   int                  recv_span;
   list_reply_type      want;

   array_list_engine #(
      .CAPACITY(LIST_CAPACITY)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // apply one operation to the list picture and return the reply it gives
   function automatic list_reply_type apply_list_op(input list_cmd_type c);
      list_reply_type r;
      int k;
      r.status  = ale_pkg::ST_OK;
      r.removed = '0;
      r.found   = '0;
      case (c.op)
         ale_pkg::OP_INSERT: begin
            // position check wins over the full check
            if (c.pos == 0 || int'(c.pos) > list_size + 1) begin
               r.status = ale_pkg::ST_BAD_POS;
            end else if (list_size >= LIST_CAPACITY) begin
               r.status = ale_pkg::ST_FULL;
            end else begin
               for (k = list_size; k > int'(c.pos) - 1; k--)
                  list_image[k] = list_image[k - 1];
               list_image[c.pos - 1] = c.val;
               list_size++;
            end
         end
         ale_pkg::OP_DELETE: begin
            if (c.pos == 0 || int'(c.pos) > list_size) begin
               r.status = ale_pkg::ST_BAD_POS;
            end else begin
               r.removed = list_image[c.pos - 1];
               for (k = c.pos; k < list_size; k++)
                  list_image[k - 1] = list_image[k];
               list_size--;
            end
         end
         ale_pkg::OP_LOCATE: begin
            // first match wins, scan stops at the held length
            r.status = ale_pkg::ST_NOT_FOUND;
            for (k = 0; k < list_size && r.status == ale_pkg::ST_NOT_FOUND; k++) begin
               if (list_image[k] == c.val) begin
                  r.status = ale_pkg::ST_OK;
                  r.found  = 8'(k + 1);
               end
            end
         end
         default: begin
            list_size = 0;
         end
      endcase
      r.length = list_size[7:0];
      return r;
   endfunction

   // queue one item and track the length it should leave behind
   task automatic add_cmd(input ale_pkg::op_type op, input int pos,
                          input logic signed [31:0] val, input bit drain);
      list_cmd_type c;
      c.op          = op;
      c.pos         = pos[7:0];
      c.val         = val;
      c.drain_first = drain;
      cmd_backlog.push_back(c);
      case (op)
         ale_pkg::OP_INSERT:
            if (pos >= 1 && pos <= plan_len + 1 && plan_len < LIST_CAPACITY) plan_len++;
         ale_pkg::OP_DELETE:
            if (pos >= 1 && pos <= plan_len) plan_len--;
         ale_pkg::OP_CLEAR:
            plan_len = 0;
         default: ;
      endcase
   endtask

   // mostly values from a small pool so locate hits and duplicates are common
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 99) < 70)
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // idle length: mostly none, often short, now and then long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, GAP_MAX);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at reply %0d: %s", reply_index, what);
      mismatch_count++;
   endtask

   // sender: offer items from the backlog, take the prediction on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_operation <= ale_pkg::OP_INSERT;
         req_position  <= '0;
         req_value     <= '0;
         send_gap      <= 0;
         send_calm     <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_list_op(in_flight));
            reqs_taken <= reqs_taken + 1;
         end
         if (req_valid && req_stall) begin
            // offered item stays put while stalled
         end else if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (cmd_backlog.size() != 0 &&
                      !(cmd_backlog[0].drain_first && expected_replies.size() != 0)) begin
            in_flight = cmd_backlog.pop_front();
            req_valid     <= 1'b1;
            req_operation <= in_flight.op;
            req_position  <= in_flight.pos;
            req_value     <= in_flight.val;
            // gap that follows this item once it is taken
            if (send_calm != 0) begin
               send_calm <= send_calm - 1;
               send_gap  <= 0;
            end else begin
               send_gap <= idle_span();
               if ($urandom_range(0, 99) < 3) send_calm <= $urandom_range(20, 80);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random stalls, calm stretches, and periodic long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_left   <= 0;
         recv_calm    <= 0;
         hold_left    <= 0;
         next_hold_at <= 60;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (reqs_taken >= next_hold_at) begin
         // sender keeps offering while we hold, so the block backs up
         rsp_stall    <= 1'b1;
         hold_left    <= LONG_HOLD;
         next_hold_at <= next_hold_at + HOLD_EVERY;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (recv_calm != 0) begin
         rsp_stall <= 1'b0;
         recv_calm <= recv_calm - 1;
      end else begin
         recv_span = idle_span();
         rsp_stall  <= (recv_span != 0);
         stall_left <= (recv_span != 0) ? recv_span - 1 : 0;
         if ($urandom_range(0, 99) < 3) recv_calm <= $urandom_range(20, 80);
      end
   end

   // monitor: compare each accepted reply with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("reply with no item outstanding");
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_removed_value !== want.removed)
               report_mismatch($sformatf("removed_value %0d, expected %0d",
                                         rsp_removed_value, want.removed));
            if (rsp_found_position !== want.found)
               report_mismatch($sformatf("found_position %0d, expected %0d",
                                         rsp_found_position, want.found));
            if (rsp_list_length !== want.length)
               report_mismatch($sformatf("list_length %0d, expected %0d",
                                         rsp_list_length, want.length));
         end
         reply_index <= reply_index + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int n;
      int r;
      int pos;
      int limit;
      int target;
      ale_pkg::op_type op;

      value_pool[0] = 32'sh0000_0000;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh8000_0000;
      value_pool[3] = 32'sh7fff_ffff;
      for (n = 4; n < POOL_SIZE; n++) value_pool[n] = $urandom;

      // directed: empty-list errors, bad positions, ends and middle, duplicates
      add_cmd(ale_pkg::OP_DELETE, 1, $urandom, 1'b0);          // delete from empty list
      add_cmd(ale_pkg::OP_LOCATE, 0, 0, 1'b0);                 // locate in empty list
      add_cmd(ale_pkg::OP_INSERT, 0, 5, 1'b0);                 // position zero
      add_cmd(ale_pkg::OP_INSERT, 2, 6, 1'b0);                 // past length + 1
      add_cmd(ale_pkg::OP_INSERT, 1, 32'sh7fff_ffff, 1'b0);
      add_cmd(ale_pkg::OP_INSERT, 2, 32'sh8000_0000, 1'b0);    // append at the end
      add_cmd(ale_pkg::OP_INSERT, 1, -32'sd1, 1'b0);           // push at the front
      add_cmd(ale_pkg::OP_INSERT, 2, 0, 1'b0);                 // middle
      add_cmd(ale_pkg::OP_INSERT, 255, 7, 1'b0);               // all position bits set
      add_cmd(ale_pkg::OP_INSERT, 6, 8, 1'b0);                 // one past the end
      add_cmd(ale_pkg::OP_INSERT, 3, -32'sd1, 1'b0);           // duplicate value
      add_cmd(ale_pkg::OP_LOCATE, 255, -32'sd1, 1'b0);         // first of two matches
      add_cmd(ale_pkg::OP_LOCATE, 0, 32'sh8000_0000, 1'b0);    // last entry
      add_cmd(ale_pkg::OP_LOCATE, $urandom_range(0, 255), 12345, 1'b0);  // no match
      add_cmd(ale_pkg::OP_DELETE, 0, $urandom, 1'b0);
      add_cmd(ale_pkg::OP_DELETE, 6, $urandom, 1'b0);          // one past the length
      add_cmd(ale_pkg::OP_DELETE, 255, $urandom, 1'b0);
      add_cmd(ale_pkg::OP_DELETE, 5, $urandom, 1'b0);          // last entry
      add_cmd(ale_pkg::OP_DELETE, 1, $urandom, 1'b0);          // first entry
      add_cmd(ale_pkg::OP_DELETE, 2, $urandom, 1'b0);          // middle
      add_cmd(ale_pkg::OP_LOCATE, 255, 32'sh7fff_ffff, 1'b0);
      add_cmd(ale_pkg::OP_CLEAR, 255, -32'sd1, 1'b0);          // clear ignores its fields
      add_cmd(ale_pkg::OP_LOCATE, 0, 0, 1'b0);                 // nothing held after clear
      add_cmd(ale_pkg::OP_INSERT, 1, $urandom, 1'b0);
      add_cmd(ale_pkg::OP_CLEAR, 0, 0, 1'b0);

      // fill to capacity, hit the full case, then drain part of it again
      add_cmd(ale_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom, 1'b1);
      while (plan_len < LIST_CAPACITY)
         add_cmd(ale_pkg::OP_INSERT, $urandom_range(1, plan_len + 1), pick_value(), 1'b0);
      add_cmd(ale_pkg::OP_INSERT, 1, pick_value(), 1'b0);                    // full
      add_cmd(ale_pkg::OP_INSERT, LIST_CAPACITY + 1, pick_value(), 1'b0);    // full, at end
      add_cmd(ale_pkg::OP_INSERT, LIST_CAPACITY / 2, pick_value(), 1'b0);    // full
      add_cmd(ale_pkg::OP_INSERT, LIST_CAPACITY + 2, pick_value(), 1'b0);    // bad beats full
      add_cmd(ale_pkg::OP_INSERT, 0, pick_value(), 1'b0);                    // bad beats full
      for (n = 0; n < 4; n++)
         add_cmd(ale_pkg::OP_LOCATE, $urandom_range(0, 255), pick_value(), 1'b0);
      add_cmd(ale_pkg::OP_DELETE, LIST_CAPACITY + 1, $urandom, 1'b0);
      add_cmd(ale_pkg::OP_DELETE, LIST_CAPACITY, $urandom, 1'b0);
      add_cmd(ale_pkg::OP_DELETE, 1, $urandom, 1'b0);
      for (n = 0; n < 20; n++)
         add_cmd(ale_pkg::OP_DELETE, $urandom_range(1, plan_len), $urandom, 1'b0);
      add_cmd(ale_pkg::OP_LOCATE, $urandom_range(0, 255), pick_value(), 1'b0);
      add_cmd(ale_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom, 1'b0);

      // random: length wanders toward a target, mostly small lists
      target = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 0)
            target = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 16)
                                                 : $urandom_range(16, LIST_CAPACITY);
         r = $urandom_range(0, 99);
         if (r < 2) begin
            add_cmd(ale_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom, n % 500 == 250);
         end else if (r < 22) begin
            add_cmd(ale_pkg::OP_LOCATE, $urandom_range(0, 255), pick_value(), n % 500 == 250);
         end else begin
            op = ($urandom_range(0, 99) < ((plan_len < target) ? 75 : 25)) ?
                 ale_pkg::OP_INSERT : ale_pkg::OP_DELETE;
            limit = (op == ale_pkg::OP_INSERT) ? plan_len + 1 : plan_len;
            r = $urandom_range(0, 99);
            // a few bad positions, ends favored, the rest anywhere in range
            if (r < 6) pos = 0;
            else if (r < 12 || limit == 0) pos = $urandom_range(limit + 1, 255);
            else if (r < 20) pos = 1;
            else if (r < 28) pos = limit;
            else pos = $urandom_range(1, limit);
            add_cmd(op, pos, pick_value(), n % 500 == 250);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for the backlog to go out and every reply to come back
      while (cmd_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      // room for any stray reply to show up
      repeat (LIST_CAPACITY + 10) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
